/* src/bmpd_pkg.sv */
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the BMP stream pixel decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REG_EXPECTED_WIDTH  = 2'd0;
    localparam logic [1:0] REG_EXPECTED_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KEEP_BGR_ORDER  = 2'd2;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_BAD_SIG     = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEADER  = 3'd2;
    localparam logic [2:0] STATUS_SIZE        = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED   = 3'd4;

    localparam logic [31:0] MIN_FILE_BYTES = 32'd54;
    localparam logic [31:0] MIN_DIB_BYTES  = 32'd40;
    localparam logic [7:0]  SIG_FIRST      = 8'h42;
    localparam logic [7:0]  SIG_SECOND     = 8'h4D;

    typedef struct packed {
        logic       pix_valid;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0] chan_first;
        logic [7:0] chan_middle;
        logic [7:0] chan_final;
        logic       stat_valid;
        logic [2:0] code;
    } queue_entry_t;

endpackage

/* src/bmpd_front.sv */
// ----------------------------------------------------------------------------
// bmpd_front
// Parses the file header byte by byte and classifies pixel bytes.
// ----------------------------------------------------------------------------
module bmpd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [12:0]           exp_width,
    input  logic [12:0]           exp_height,
    input  logic                  keep_bgr,
    output logic                  push,
    output bmpd_pkg::queue_entry_t push_entry
);
    import bmpd_pkg::*;

    logic [31:0] pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] hsize_reg, hsize_next;
    logic [31:0] fwidth_reg, fwidth_next;
    logic [31:0] fheight_reg, fheight_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] comp_reg, comp_next;
    logic [2:0]  err_reg, err_next;
    logic [12:0] src_reg, src_next;
    logic [14:0] rowbytes_reg, rowbytes_next;
    logic [12:0] col_reg, col_next;
    logic [1:0]  sub_reg, sub_next;
    logic [7:0]  hold0_reg, hold0_next;
    logic [7:0]  hold1_reg, hold1_next;
    logic [12:0] dstrow_reg, dstrow_next;
    logic        topdown_reg, topdown_next;
    logic [12:0] height_reg, height_next;
    logic [12:0] width_reg, width_next;
    logic [14:0] rowsize_reg, rowsize_next;
    logic        bpp32_reg, bpp32_next;

    logic [31:0] mag_h;
    logic [31:0] pos_inc;
    logic        hdr_bad, size_bad, in_pixels, pix_emit;
    logic [14:0] w3;
    logic [2:0]  code;

    assign mag_h   = fheight_reg[31] ? (32'd0 - fheight_reg) : fheight_reg;
    assign pos_inc = (pos_reg == 32'hFFFF_FFFF) ? pos_reg : pos_reg + 32'd1;
    assign w3      = {2'b00, fwidth_reg[12:0]} + {1'b0, fwidth_reg[12:0], 1'b0};

    always_comb begin
        hdr_bad = (hsize_reg < MIN_DIB_BYTES)
            || (depth_reg != 16'd24 && depth_reg != 16'd32)
            || ({data_byte, comp_reg[23:0]} != 32'd0 && {data_byte, comp_reg[23:0]} != 32'd3)
            || (offset_reg < MIN_FILE_BYTES);
        size_bad = fwidth_reg[31] || (fwidth_reg == 32'd0) || (mag_h == 32'd0)
            || (fwidth_reg != {19'd0, exp_width}) || (mag_h != {19'd0, exp_height})
            || (fwidth_reg > 32'(MAX_WIDTH)) || (mag_h > 32'(MAX_HEIGHT));
    end

    always_comb begin
        pos_next      = pos_inc;
        offset_next   = offset_reg;
        hsize_next    = hsize_reg;
        fwidth_next   = fwidth_reg;
        fheight_next  = fheight_reg;
        depth_next    = depth_reg;
        comp_next     = comp_reg;
        err_next      = err_reg;
        src_next      = src_reg;
        rowbytes_next = rowbytes_reg;
        col_next      = col_reg;
        sub_next      = sub_reg;
        hold0_next    = hold0_reg;
        hold1_next    = hold1_reg;
        dstrow_next   = dstrow_reg;
        topdown_next  = topdown_reg;
        height_next   = height_reg;
        width_next    = width_reg;
        rowsize_next  = rowsize_reg;
        bpp32_next    = bpp32_reg;
        pix_emit      = 1'b0;

        if (err_reg == STATUS_OK && ((pos_reg == 32'd0 && data_byte != SIG_FIRST)
                || (pos_reg == 32'd1 && data_byte != SIG_SECOND))) begin
            err_next = STATUS_BAD_SIG;
        end
        case (pos_reg)
            32'd10: offset_next[7:0]    = data_byte;
            32'd11: offset_next[15:8]   = data_byte;
            32'd12: offset_next[23:16]  = data_byte;
            32'd13: offset_next[31:24]  = data_byte;
            32'd14: hsize_next[7:0]     = data_byte;
            32'd15: hsize_next[15:8]    = data_byte;
            32'd16: hsize_next[23:16]   = data_byte;
            32'd17: hsize_next[31:24]   = data_byte;
            32'd18: fwidth_next[7:0]    = data_byte;
            32'd19: fwidth_next[15:8]   = data_byte;
            32'd20: fwidth_next[23:16]  = data_byte;
            32'd21: fwidth_next[31:24]  = data_byte;
            32'd22: fheight_next[7:0]   = data_byte;
            32'd23: fheight_next[15:8]  = data_byte;
            32'd24: fheight_next[23:16] = data_byte;
            32'd25: fheight_next[31:24] = data_byte;
            32'd28: depth_next[7:0]     = data_byte;
            32'd29: depth_next[15:8]    = data_byte;
            32'd30: comp_next[7:0]      = data_byte;
            32'd31: comp_next[15:8]     = data_byte;
            32'd32: comp_next[23:16]    = data_byte;
            32'd33: comp_next[31:24]    = data_byte;
            default: ;
        endcase

        if (pos_reg == 32'd33 && err_reg == STATUS_OK) begin
            if (hdr_bad) begin
                err_next = STATUS_BAD_HEADER;
            end else if (size_bad) begin
                err_next = STATUS_SIZE;
            end else begin
                topdown_next = fheight_reg[31];
                height_next  = mag_h[12:0];
                width_next   = fwidth_reg[12:0];
                bpp32_next   = (depth_reg == 16'd32);
                dstrow_next  = fheight_reg[31] ? 13'd0 : mag_h[12:0] - 13'd1;
                rowsize_next = (depth_reg == 16'd32) ? {fwidth_reg[12:0], 2'b00}
                                                    : ((w3 + 15'd3) & 15'h7FFC);
            end
        end

        in_pixels = (err_reg == STATUS_OK) && (pos_reg >= 32'd34)
            && (pos_reg >= offset_reg) && (src_reg < height_reg);
        if (in_pixels) begin
            if (col_reg < width_reg) begin
                if (sub_reg == 2'd0) hold0_next = data_byte;
                if (sub_reg == 2'd1) hold1_next = data_byte;
                pix_emit = (sub_reg == 2'd2);
                if (sub_reg == (bpp32_reg ? 2'd3 : 2'd2)) begin
                    col_next = col_reg + 13'd1;
                    sub_next = 2'd0;
                end else begin
                    sub_next = sub_reg + 2'd1;
                end
            end
            rowbytes_next = rowbytes_reg + 15'd1;
            if (rowbytes_next >= rowsize_reg) begin
                rowbytes_next = 15'd0;
                col_next      = 13'd0;
                sub_next      = 2'd0;
                src_next      = src_reg + 13'd1;
                dstrow_next   = topdown_reg ? dstrow_reg + 13'd1 : dstrow_reg - 13'd1;
            end
        end

        if (pos_next < MIN_FILE_BYTES)   code = STATUS_BAD_SIG;
        else if (err_next != STATUS_OK)  code = err_next;
        else if (src_next < height_next) code = STATUS_TRUNCATED;
        else                             code = STATUS_OK;
    end

    assign push = in_accept && (pix_emit || last_byte);
    always_comb begin
        push_entry.pix_valid   = pix_emit;
        push_entry.row         = dstrow_reg[11:0];
        push_entry.column      = col_reg[11:0];
        push_entry.chan_first  = keep_bgr ? hold0_reg : data_byte;
        push_entry.chan_middle = hold1_reg;
        push_entry.chan_final  = keep_bgr ? data_byte : hold0_reg;
        push_entry.stat_valid  = last_byte;
        push_entry.code        = code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && last_byte)) begin
            pos_reg      <= '0;
            offset_reg   <= '0;
            hsize_reg    <= '0;
            fwidth_reg   <= '0;
            fheight_reg  <= '0;
            depth_reg    <= '0;
            comp_reg     <= '0;
            err_reg      <= STATUS_OK;
            src_reg      <= '0;
            rowbytes_reg <= '0;
            col_reg      <= '0;
            sub_reg      <= '0;
            hold0_reg    <= '0;
            hold1_reg    <= '0;
            dstrow_reg   <= '0;
            topdown_reg  <= 1'b0;
            height_reg   <= '0;
            width_reg    <= '0;
            rowsize_reg  <= '0;
            bpp32_reg    <= 1'b0;
        end else if (in_accept) begin
            pos_reg      <= pos_next;
            offset_reg   <= offset_next;
            hsize_reg    <= hsize_next;
            fwidth_reg   <= fwidth_next;
            fheight_reg  <= fheight_next;
            depth_reg    <= depth_next;
            comp_reg     <= comp_next;
            err_reg      <= err_next;
            src_reg      <= src_next;
            rowbytes_reg <= rowbytes_next;
            col_reg      <= col_next;
            sub_reg      <= sub_next;
            hold0_reg    <= hold0_next;
            hold1_reg    <= hold1_next;
            dstrow_reg   <= dstrow_next;
            topdown_reg  <= topdown_next;
            height_reg   <= height_next;
            width_reg    <= width_next;
            rowsize_reg  <= rowsize_next;
            bpp32_reg    <= bpp32_next;
        end
    end

endmodule

/* src/bmpd_queue.sv */
// ----------------------------------------------------------------------------
// bmpd_queue
// Short queue of decoded entries between the parser and the output stage.
// ----------------------------------------------------------------------------
module bmpd_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  bmpd_pkg::queue_entry_t push_entry,
    output logic                   full,
    output logic                   pop_valid,
    input  logic                   pop,
    output bmpd_pkg::queue_entry_t pop_entry
);
    import bmpd_pkg::*;

    queue_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !pop_valid)) else $error("Queue read while empty.");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("Queue count out of range.");

endmodule

/* src/bmpd_back.sv */
// ----------------------------------------------------------------------------
// bmpd_back
// Output register that turns queue entries into pixel and status transfers.
// ----------------------------------------------------------------------------
module bmpd_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  bmpd_pkg::queue_entry_t q_entry,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import bmpd_pkg::*;

    logic        valid_reg;
    logic        kind_reg, end_reg;
    logic [11:0] row_reg, col_reg;
    logic [7:0]  c0_reg, c1_reg, c2_reg;
    logic [2:0]  code_reg;
    logic        pend_reg;
    logic [2:0]  pend_code_reg;
    logic        load;

    assign load  = !valid_reg || m_tready;
    assign q_pop = load && !pend_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
                kind_reg  <= 1'b1;
                end_reg   <= 1'b1;
                row_reg   <= '0;
                col_reg   <= '0;
                c0_reg    <= '0;
                c1_reg    <= '0;
                c2_reg    <= '0;
                code_reg  <= pend_code_reg;
            end else if (q_valid) begin
                valid_reg     <= 1'b1;
                pend_reg      <= q_entry.pix_valid && q_entry.stat_valid;
                pend_code_reg <= q_entry.code;
                kind_reg      <= !q_entry.pix_valid;
                end_reg       <= !(q_entry.pix_valid && q_entry.stat_valid);
                row_reg       <= q_entry.pix_valid ? q_entry.row : 12'd0;
                col_reg       <= q_entry.pix_valid ? q_entry.column : 12'd0;
                c0_reg        <= q_entry.pix_valid ? q_entry.chan_first : 8'd0;
                c1_reg        <= q_entry.pix_valid ? q_entry.chan_middle : 8'd0;
                c2_reg        <= q_entry.pix_valid ? q_entry.chan_final : 8'd0;
                code_reg      <= q_entry.pix_valid ? STATUS_OK : q_entry.code;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = end_reg;
    assign m_tdata  = {5'd0, code_reg, c2_reg, c1_reg, c0_reg, col_reg, row_reg};

    a_status_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg) |-> end_reg) else $error("Status without run end.");
    a_pending_follows_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (valid_reg && !kind_reg && !end_reg))
        else $error("Pending status without a pixel ahead of it.");
    a_pixel_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !kind_reg) |-> (code_reg == STATUS_OK))
        else $error("Pixel carries a status code.");

endmodule

/* src/bmp_stream_pixel_decoder_core.sv */
// ----------------------------------------------------------------------------
// bmp_stream_pixel_decoder_core
// BMP byte stream decoder for 24 and 32 bit pixels with a config port.
// ----------------------------------------------------------------------------
// A result is written into the queue and then into the output register.
// Throughput is one byte per cycle while the queue is not full.
// A last byte that also completes a pixel gives two results: the pixel, then the status.
// The synchronous active-low reset clears the stream state and the queue and
// loads the registers with width 640, height 480 and BGR order.
module bmp_stream_pixel_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_row, out_column, channel_first,
                                   // channel_middle, channel_final, status_code
    output logic        m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import bmpd_pkg::*;

    logic [12:0]  exp_width_reg, exp_height_reg;
    logic         keep_bgr_reg;
    logic         q_full, q_valid, q_pop, push, in_accept;
    queue_entry_t push_entry, q_entry;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_width_reg  <= 13'd640;
            exp_height_reg <= 13'd480;
            keep_bgr_reg   <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_EXPECTED_WIDTH:  exp_width_reg  <= cfg_data;
                REG_EXPECTED_HEIGHT: exp_height_reg <= cfg_data;
                REG_KEEP_BGR_ORDER:  keep_bgr_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    bmpd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .data_byte  (s_tdata),
        .last_byte  (s_tlast),
        .exp_width  (exp_width_reg),
        .exp_height (exp_height_reg),
        .keep_bgr   (keep_bgr_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    bmpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    bmpd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* verif/bmpd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_checker
// Watches the byte, result and register channels of the BMP pixel decoder,
// decodes each accepted byte on its own copy of the parser state and compares
// every result transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module bmpd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import bmpd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [11:0] row;
        logic [11:0] column;
        logic [7:0]  ch_first;
        logic [7:0]  ch_middle;
        logic [7:0]  ch_final;
        logic [2:0]  code;
        logic        run_end;
    } pixel_result_t;

    pixel_result_t decoded_q[$];

    logic [12:0] want_width, want_height;
    logic        keep_bgr;
    logic [31:0] pos, offset, dib_size, img_width, img_height, depth, compression;
    logic [2:0]  err;
    logic [31:0] rows_done, row_bytes, column;
    logic [7:0]  hold [3];
    logic        rows_descend;

    function automatic void clear_file();
        pos = 0; offset = 0; dib_size = 0; img_width = 0; img_height = 0;
        depth = 0; compression = 0; err = STATUS_OK; rows_done = 0;
        row_bytes = 0; column = 0; rows_descend = 0;
        hold[0] = 0; hold[1] = 0; hold[2] = 0;
    endfunction

    function automatic void raise_error(logic [2:0] c);
        if (err == STATUS_OK) err = c;
    endfunction

    function automatic logic [31:0] abs_height();
        return img_height[31] ? -img_height : img_height;
    endfunction

    function automatic void validate_header();
        logic [31:0] h;
        h = abs_height();
        if (dib_size < MIN_DIB_BYTES || (depth != 24 && depth != 32) ||
            (compression != 0 && compression != 3) || offset < MIN_FILE_BYTES) begin
            raise_error(STATUS_BAD_HEADER);
            return;
        end
        if (img_width[31] || img_width == 0 || h == 0 || img_width != want_width ||
            h != want_height || img_width > MAX_WIDTH || h > MAX_HEIGHT) begin
            raise_error(STATUS_SIZE);
            return;
        end
        rows_descend = img_height[31];
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        logic [31:0] p, h, bpb, row_len, sub, sh;
        pixel_result_t r;
        int first;
        first = decoded_q.size();
        p = pos;
        if (p == 0 && b != SIG_FIRST) raise_error(STATUS_BAD_SIG);
        if (p == 1 && b != SIG_SECOND) raise_error(STATUS_BAD_SIG);
        if (p >= 10 && p <= 13) begin
            sh = 8 * (p - 10); offset |= 32'(b) << sh;
        end else if (p >= 14 && p <= 17) begin
            sh = 8 * (p - 14); dib_size |= 32'(b) << sh;
        end else if (p >= 18 && p <= 21) begin
            sh = 8 * (p - 18); img_width |= 32'(b) << sh;
        end else if (p >= 22 && p <= 25) begin
            sh = 8 * (p - 22); img_height |= 32'(b) << sh;
        end else if (p >= 28 && p <= 29) begin
            sh = 8 * (p - 28); depth |= 32'(b) << sh;
        end else if (p >= 30 && p <= 33) begin
            sh = 8 * (p - 30); compression |= 32'(b) << sh;
        end
        if (p == 33 && err == STATUS_OK) validate_header();
        h = abs_height();
        if (err == STATUS_OK && p >= 34 && p >= offset && rows_done < h) begin
            bpb = depth / 8;
            row_len = ((img_width * depth + 31) / 32) * 4;
            if (row_bytes < img_width * bpb) begin
                sub = row_bytes - column * bpb;
                if (sub < 3) hold[sub] = b;
                if (sub == 2) begin
                    r = '0;
                    r.row = rows_descend ? rows_done[11:0] : 12'(h - 1 - rows_done);
                    r.column = column[11:0];
                    r.ch_first = keep_bgr ? hold[0] : hold[2];
                    r.ch_middle = hold[1];
                    r.ch_final = keep_bgr ? hold[2] : hold[0];
                    decoded_q.push_back(r);
                end
                if (sub + 1 == bpb) column++;
            end
            row_bytes++;
            if (row_bytes >= row_len) begin
                row_bytes = 0;
                column = 0;
                rows_done++;
            end
        end
        if (pos != 32'hFFFF_FFFF) pos++;
        if (fin) begin
            r = '0;
            r.kind = 1'b1;
            if (pos < MIN_FILE_BYTES) r.code = STATUS_BAD_SIG;
            else if (err != STATUS_OK) r.code = err;
            else if (rows_done < h) r.code = STATUS_TRUNCATED;
            else r.code = STATUS_OK;
            decoded_q.push_back(r);
            clear_file();
        end
        if (decoded_q.size() > first) decoded_q[decoded_q.size() - 1].run_end = 1'b1;
    endfunction

    task automatic compare_result();
        pixel_result_t e, a;
        a.kind = m_tuser;
        a.row = m_tdata[11:0];
        a.column = m_tdata[23:12];
        a.ch_first = m_tdata[31:24];
        a.ch_middle = m_tdata[39:32];
        a.ch_final = m_tdata[47:40];
        a.code = m_tdata[50:48];
        a.run_end = m_tlast;
        if (decoded_q.size() == 0) begin
            $display("%t: unexpected result transfer %h", $time, a);
            fail_count++;
            return;
        end
        e = decoded_q.pop_front();
        if (a.kind != e.kind)
            $display("%t: kind expected %0d actual %0d", $time, e.kind, a.kind);
        if (a.row != e.row)
            $display("%t: row expected %0d actual %0d", $time, e.row, a.row);
        if (a.column != e.column)
            $display("%t: column expected %0d actual %0d", $time, e.column, a.column);
        if (a.ch_first != e.ch_first)
            $display("%t: first channel expected %h actual %h", $time, e.ch_first,
                     a.ch_first);
        if (a.ch_middle != e.ch_middle)
            $display("%t: middle channel expected %h actual %h", $time, e.ch_middle,
                     a.ch_middle);
        if (a.ch_final != e.ch_final)
            $display("%t: final channel expected %h actual %h", $time, e.ch_final,
                     a.ch_final);
        if (a.code != e.code)
            $display("%t: status expected %0d actual %0d", $time, e.code, a.code);
        if (a.run_end != e.run_end)
            $display("%t: tlast expected %0d actual %0d", $time, e.run_end, a.run_end);
        if (m_tdata[55:51] != 0)
            $display("%t: padding expected 0 actual %h", $time, m_tdata[55:51]);
        if (a != e || m_tdata[55:51] != 0) fail_count++;
    endtask

    initial begin
        fail_count = 0;
        want_width = 640; want_height = 480; keep_bgr = 1;
        clear_file();
    end

    assign pending = decoded_q.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            want_width = 640; want_height = 480; keep_bgr = 1;
            clear_file();
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EXPECTED_WIDTH: want_width = cfg_data;
                    REG_EXPECTED_HEIGHT: want_height = cfg_data;
                    REG_KEEP_BGR_ORDER: keep_bgr = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) compare_result();
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams whole and damaged BMP files into the pixel decoder with random
// gaps and result stalls, rewrites its registers between files and reports
// the verdict of the checker.
// ----------------------------------------------------------------------------
module tb;
    import bmpd_pkg::*;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready, m_tuser, m_tlast;
    logic [55:0] m_tdata;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    int          fail_count, pending;

    logic [7:0] file_q[$];
    int  bytes_sent;
    int  stall_len;
    bit  steady;
    int  cur_w, cur_h;

    bmp_stream_pixel_decoder_core uut (.*);
    bmpd_checker u_checker (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        m_tready <= 0;
        stall_len = 0;
        @(posedge aresetn);
        forever begin
            int gap;
            gap = steady ? 0 : $urandom_range(0, 4);
            if (stall_len > 0) begin
                gap = stall_len;
                stall_len = 0;
            end
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= b;
        s_tlast <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic set_size(int w, int h);
        drain();
        write_reg(REG_EXPECTED_WIDTH, 13'(w));
        write_reg(REG_EXPECTED_HEIGHT, 13'(h));
        cur_w = w;
        cur_h = h;
    endtask

    function automatic void put32(int at, int v);
        for (int i = 0; i < 4; i++) file_q[at + i] = 8'(v >> (8 * i));
    endfunction

    function automatic void build(int w, int hf, int bpp, int comp, int dib, int off,
                                  int rows, int extra);
        int rs;
        file_q.delete();
        for (int i = 0; i < 54; i++) file_q.push_back(8'($urandom));
        file_q[0] = SIG_FIRST;
        file_q[1] = SIG_SECOND;
        put32(10, off);
        put32(14, dib);
        put32(18, w);
        put32(22, hf);
        file_q[28] = 8'(bpp);
        file_q[29] = 8'(bpp >> 8);
        put32(30, comp);
        while (file_q.size() < off) file_q.push_back(8'($urandom));
        rs = ((w * bpp + 31) / 32) * 4;
        repeat (rows * rs + extra) file_q.push_back(8'($urandom));
    endfunction

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    function automatic void random_good();
        int h;
        h = cur_h;
        build(cur_w, $urandom_range(0, 1) ? -h : h, $urandom_range(0, 1) ? 24 : 32,
              $urandom_range(0, 1) ? 0 : 3, $urandom_range(40, 124),
              54 + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0), h,
              $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0);
    endfunction

    initial begin
        aresetn <= 0;
        s_tvalid <= 0; s_tdata <= 0; s_tlast <= 0;
        cfg_valid <= 0; cfg_index <= REG_EXPECTED_WIDTH; cfg_data <= 0;
        bytes_sent = 0;
        steady = 0;
        cur_w = 640; cur_h = 480;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        set_size(1, 1);
        build(1, 1, 24, 0, 40, 54, 1, 0);
        send_file();
        build(3, -2, 32, 3, 40, 60, 2, 3);
        set_size(3, 2);
        write_reg(REG_KEEP_BGR_ORDER, 0);
        stall_len = 200;
        send_file();
        build(3, 2, 24, 0, 40, 54, 0, 0);
        file_q[0] = 8'h00;
        send_file();
        build(3, 2, 24, 0, 40, 54, 0, 0);
        file_q = file_q[0:19];
        send_file();
        build(3, 2, 24, 0, 40, 53, 0, 0);
        send_file();
        build(4, 2, 24, 0, 40, 54, 0, 0);
        send_file();
        build(-3, 2, 24, 0, 40, 54, 0, 0);
        send_file();
        build(3, 0, 24, 0, 40, 54, 0, 0);
        send_file();
        build(3, 2, 24, 0, 40, 54, 1, 5);
        send_file();
        set_size(4096, 4096);
        build(4096, 4096, 24, 0, 40, 54, 0, 13);
        send_file();
        build(4096, -4096, 32, 0, 40, 54, 0, 9);
        send_file();
        set_size(2, 3);
        write_reg(REG_KEEP_BGR_ORDER, 1);

        while (bytes_sent < 650) begin
            steady = $urandom_range(0, 4) == 0;
            if ($urandom_range(0, 3) == 0) begin
                set_size($urandom_range(1, 5), $urandom_range(1, 3));
                write_reg(REG_KEEP_BGR_ORDER, 13'($urandom_range(0, 1)));
            end
            random_good();
            case ($urandom_range(0, 9))
                0: file_q[$urandom_range(0, 33)] = 8'($urandom);
                1: file_q = file_q[0:$urandom_range(0, file_q.size() - 2)];
                2: if ($urandom_range(0, 1)) drain();
                default: ;
            endcase
            send_file();
        end
        steady = 0;
        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/bmpd_pkg.sv
src/bmpd_front.sv
src/bmpd_queue.sv
src/bmpd_back.sv
src/bmp_stream_pixel_decoder_core.sv
verif/bmpd_checker.sv
verif/tb.sv
